>>> rtl/tsfilt_pkg.sv
// Package: shared constants, types and helpers of the three-field substring filter
package tsfilt_pkg;

    // Field geometry
    localparam int STRING_CHARS = 8;
    localparam int TEXT_W       = 64;
    localparam int LEN_W        = $clog2(STRING_CHARS + 1);

    // List bookkeeping
    localparam int MAX_RECORDS  = 1024;
    localparam int INDEX_W      = 10;
    localparam int COUNT_W      = 11;
    localparam int INDEX_CAP    = (MAX_RECORDS - 1 > 1023) ? 1023 : MAX_RECORDS - 1;
    localparam int COUNT_CAP    = (MAX_RECORDS > 2047) ? 2047 : MAX_RECORDS;

    // Configuration port
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_ADDR_W   = 5;

    // Register indexes (paddr[4:3])
    localparam logic [1:0] REG_NAME    = 2'd0;
    localparam logic [1:0] REG_SURNAME = 2'd1;
    localparam logic [1:0] REG_PHONE   = 2'd2;

    // Lane results handed to the merge stage
    typedef struct packed {
        logic name_hit;
        logic surname_hit;
        logic phone_hit;
        logic last;
    } tsfilt_hits_t;

    // Length of zero-terminated text, capped at STRING_CHARS
    function automatic logic [LEN_W-1:0] text_len(input logic [TEXT_W-1:0] text);
        logic [LEN_W-1:0] len;
        len = LEN_W'(STRING_CHARS);
        for (int k = STRING_CHARS - 1; k >= 0; k--) begin
            if (text[k*8 +: 8] == 8'd0) begin
                len = LEN_W'(k);
            end
        end
        return len;
    endfunction

endpackage

>>> rtl/tsfilt_rec_if.sv
// Interface: record input channel
interface tsfilt_rec_if;
    logic                            valid;
    logic                            ready;
    logic [tsfilt_pkg::TEXT_W-1:0]   name_text;
    logic [tsfilt_pkg::TEXT_W-1:0]   surname_text;
    logic [tsfilt_pkg::TEXT_W-1:0]   phone_text;
    logic                            last_record;

    modport source (
        output valid, name_text, surname_text, phone_text, last_record,
        input  ready
    );
    modport sink (
        input  valid, name_text, surname_text, phone_text, last_record,
        output ready
    );
endinterface

>>> rtl/tsfilt_res_if.sv
// Interface: result output channel
interface tsfilt_res_if;
    logic                             valid;
    logic                             ready;
    logic                             record_match;
    logic [tsfilt_pkg::INDEX_W-1:0]   record_index;
    logic [tsfilt_pkg::COUNT_W-1:0]   match_count;
    logic                             list_end;

    modport source (
        output valid, record_match, record_index, match_count, list_end,
        input  ready
    );
    modport sink (
        input  valid, record_match, record_index, match_count, list_end,
        output ready
    );
endinterface

>>> rtl/three_field_substring_filter_core.sv
// Top level: three-field substring filter with APB pattern registers
//
// Records enter on the rec channel (valid/ready, transfer when both high),
// one per cycle while results are taken. Each carries name, surname and phone text,
// zero padded, byte 0 in bits 7:0, plus a last_record mark.
// Three pattern registers sit on the APB port at byte addresses 0, 8, 16
// (64-bit data); a pattern whose byte 0 is zero is ignored.
// Three lanes search their field in parallel into hit registers, then the merge
// stage ANDs the lane hits and updates the record index and match count.
// A record reaches res.valid through the lane hit registers and then the result
// register; throughput is one record per cycle while res.ready stays high.
// Each record gives one result on the res channel: match flag, index,
// saturating match count and the echoed list end. Counters clear after a
// record marked last.
// If res.ready stays low the result register and the lane stage hold; the
// block takes one more record into the lane stage only if that stage is empty, then drops rec.ready.
// Reset clears the patterns, the counters and all valid state.
module three_field_substring_filter_core (
    input  logic                                clk,
    input  logic                                rst_n,
    tsfilt_rec_if.sink                          rec,
    tsfilt_res_if.source                        res,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tsfilt_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [tsfilt_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [tsfilt_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                                pready
);

    localparam int DW = tsfilt_pkg::CFG_DATA_W;

    logic [DW-1:0]              name_pat_reg;
    logic [DW-1:0]              surname_pat_reg;
    logic [DW-1:0]              phone_pat_reg;
    logic [1:0]                 reg_sel;
    logic                       cfg_write;
    logic                       s1_valid_reg;
    logic                       s1_load;
    logic                       s2_ready;
    logic                       last_reg;
    tsfilt_pkg::tsfilt_hits_t   hits;

    // APB register file
    assign pready    = 1'b1;
    assign reg_sel   = paddr[4:3];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            name_pat_reg    <= '0;
            surname_pat_reg <= '0;
            phone_pat_reg   <= '0;
        end else if (cfg_write) begin
            unique case (reg_sel)
                tsfilt_pkg::REG_NAME:    name_pat_reg    <= pwdata;
                tsfilt_pkg::REG_SURNAME: surname_pat_reg <= pwdata;
                tsfilt_pkg::REG_PHONE:   phone_pat_reg   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            tsfilt_pkg::REG_NAME:    prdata = name_pat_reg;
            tsfilt_pkg::REG_SURNAME: prdata = surname_pat_reg;
            tsfilt_pkg::REG_PHONE:   prdata = phone_pat_reg;
            default:                 prdata = '0;
        endcase
    end

    // Lane stage handshake
    assign rec.ready = !s1_valid_reg || s2_ready;
    assign s1_load   = rec.valid && rec.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end else if (rec.ready) begin
            s1_valid_reg <= rec.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load) begin
            last_reg <= rec.last_record;
        end
    end

    // Parallel field lanes
    tsfilt_lane u_lane_name (
        .clk        (clk),
        .load       (s1_load),
        .field_text (rec.name_text),
        .pattern    (name_pat_reg),
        .hit        (hits.name_hit)
    );

    tsfilt_lane u_lane_surname (
        .clk        (clk),
        .load       (s1_load),
        .field_text (rec.surname_text),
        .pattern    (surname_pat_reg),
        .hit        (hits.surname_hit)
    );

    tsfilt_lane u_lane_phone (
        .clk        (clk),
        .load       (s1_load),
        .field_text (rec.phone_text),
        .pattern    (phone_pat_reg),
        .hit        (hits.phone_hit)
    );

    assign hits.last = last_reg;

    // Merge and counters
    tsfilt_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s1_valid_reg),
        .in_ready (s2_ready),
        .in_hits  (hits),
        .res      (res)
    );

endmodule

>>> rtl/tsfilt_lane.sv
// Lane: substring search of one pattern in one text field, result registered
module tsfilt_lane (
    input  logic                            clk,
    input  logic                            load,
    input  logic [tsfilt_pkg::TEXT_W-1:0]   field_text,
    input  logic [tsfilt_pkg::TEXT_W-1:0]   pattern,
    output logic                            hit
);

    localparam int SC    = tsfilt_pkg::STRING_CHARS;
    localparam int LW    = tsfilt_pkg::LEN_W;
    localparam int SUM_W = LW + 1;

    logic [LW-1:0]          flen;
    logic [LW-1:0]          plen;
    logic [SC-1:0][SC-1:0]  eq;
    logic [SC-1:0]          start_ok;
    logic                   hit_next;
    logic                   hit_reg;

    assign flen = tsfilt_pkg::text_len(field_text);
    assign plen = tsfilt_pkg::text_len(pattern);

    // Byte compare matrix: start position i, pattern byte j
    always_comb
    begin
        eq = '0;
        for (int i = 0; i < SC; i++) begin
            for (int j = 0; j < SC - i; j++) begin
                eq[i][j] = (field_text[(i+j)*8 +: 8] == pattern[j*8 +: 8]);
            end
        end
    end

    // Occurrence at start i must fit inside the field text
    always_comb
    begin
        for (int i = 0; i < SC; i++) begin
            start_ok[i] = ((SUM_W'(i) + {1'b0, plen}) <= {1'b0, flen});
            for (int j = 0; j < SC; j++) begin
                if ((LW'(j) < plen) && !eq[i][j]) begin
                    start_ok[i] = 1'b0;
                end
            end
        end
    end

    // Unused pattern (byte 0 zero) always passes
    assign hit_next = (pattern[7:0] == 8'd0) || (|start_ok);

    always_ff @(posedge clk)
    begin
        if (load) begin
            hit_reg <= hit_next;
        end
    end

    assign hit = hit_reg;

endmodule

>>> rtl/tsfilt_merge.sv
// Merge: combines lane hits, keeps list counters, drives the result register
module tsfilt_merge (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  tsfilt_pkg::tsfilt_hits_t    in_hits,
    tsfilt_res_if.source                res
);

    localparam int IW = tsfilt_pkg::INDEX_W;
    localparam int CW = tsfilt_pkg::COUNT_W;

    logic           load;
    logic           hit;
    logic [IW-1:0]  index_reg;
    logic [IW-1:0]  index_next;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic [CW-1:0]  count_now;
    logic           out_valid_reg;
    logic           out_match_reg;
    logic [IW-1:0]  out_index_reg;
    logic [CW-1:0]  out_count_reg;
    logic           out_end_reg;

    // Output register frees when empty or taken this cycle
    assign in_ready = !out_valid_reg || res.ready;
    assign load     = in_valid && in_ready;

    assign hit = in_hits.name_hit && in_hits.surname_hit && in_hits.phone_hit;

    // Count including this record, saturating
    assign count_now = (hit && (count_reg < CW'(tsfilt_pkg::COUNT_CAP)))
                       ? count_reg + CW'(1) : count_reg;

    // Counters restart after the list end
    always_comb
    begin
        if (in_hits.last) begin
            index_next = '0;
            count_next = '0;
        end else begin
            count_next = count_now;
            if (index_reg < IW'(tsfilt_pkg::INDEX_CAP)) begin
                index_next = index_reg + IW'(1);
            end else begin
                index_next = index_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            index_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                index_reg <= index_next;
                count_reg <= count_next;
            end
            if (in_ready) begin
                out_valid_reg <= in_valid;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (load) begin
            out_match_reg <= hit;
            out_index_reg <= index_reg;
            out_count_reg <= count_now;
            out_end_reg   <= in_hits.last;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.record_match = out_match_reg;
    assign res.record_index = out_index_reg;
    assign res.match_count  = out_count_reg;
    assign res.list_end     = out_end_reg;

`ifndef SYNTH
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(tsfilt_pkg::COUNT_CAP))
        else $error("match counter beyond cap");

    a_index_cap: assert property (@(posedge clk) disable iff (!rst_n)
        index_reg <= IW'(tsfilt_pkg::INDEX_CAP))
        else $error("index counter beyond cap");

    a_list_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (load && in_hits.last) |=> (index_reg == '0 && count_reg == '0))
        else $error("counters not cleared after list end");

    a_match_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (load && hit) |=> (out_count_reg != '0))
        else $error("matching record shows zero count");
`endif

endmodule

>>> tb/three_field_substring_filter_core_test.sv
// Testbench: self-checking test of the three-field substring filter core
module three_field_substring_filter_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         TEXT_W       = tsfilt_pkg::TEXT_W;
    localparam int         INDEX_W      = tsfilt_pkg::INDEX_W;
    localparam int         COUNT_W      = tsfilt_pkg::COUNT_W;
    localparam int         CFG_ADDR_W   = tsfilt_pkg::CFG_ADDR_W;
    localparam int         CFG_DATA_W   = tsfilt_pkg::CFG_DATA_W;
    localparam int         STRING_CHARS = tsfilt_pkg::STRING_CHARS;
    localparam int         INDEX_CAP    = tsfilt_pkg::INDEX_CAP;
    localparam int         COUNT_CAP    = tsfilt_pkg::COUNT_CAP;

    localparam int         CYCLE_LIMIT  = 200_000;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         HOLD_CYCLES  = 400;
    localparam int         MAX_GAP      = 20;
    localparam logic [1:0] REG_SPARE    = 2'd3;   // unmapped slot, writes are dropped

    typedef struct packed {
        logic [TEXT_W-1:0] name_text;
        logic [TEXT_W-1:0] surname_text;
        logic [TEXT_W-1:0] phone_text;
        logic              last_record;
    } record_t;

    typedef struct packed {
        logic               record_match;
        logic [INDEX_W-1:0] record_index;
        logic [COUNT_W-1:0] match_count;
        logic               list_end;
    } verdict_t;

    typedef enum logic {ROW_PATTERN, ROW_RECORD} row_kind_t;

    // Pattern rows carry the register value in name_text
    typedef struct packed {
        row_kind_t          kind;
        logic [1:0]         reg_idx;
        logic [TEXT_W-1:0]  name_text;
        logic [TEXT_W-1:0]  surname_text;
        logic [TEXT_W-1:0]  phone_text;
        logic               last_record;
        logic               typed;
        logic               hit;
        logic [INDEX_W-1:0] index;
        logic [COUNT_W-1:0] tally;
    } plan_row_t;

    localparam int PLAN_ROWS = 24;

    localparam logic [TEXT_W-1:0] ONES = {TEXT_W{1'b1}};

    plan_row_t plan [PLAN_ROWS] = '{
        // no pattern in use: everything matches, fields at both extremes
        '{ROW_RECORD,  tsfilt_pkg::REG_NAME, '0, '0, '0,
          1'b0, 1'b1, 1'b1, 10'd0, 11'd1},
        '{ROW_RECORD,  tsfilt_pkg::REG_NAME, ONES, ONES, ONES,
          1'b1, 1'b1, 1'b1, 10'd1, 11'd2},
        // name pattern "ab", stray write to the unmapped slot
        '{ROW_PATTERN, tsfilt_pkg::REG_NAME, 64'h6261, '0, '0,
          1'b0, 1'b0, 1'b0, '0, '0},
        '{ROW_PATTERN, REG_SPARE, ONES, '0, '0,
          1'b0, 1'b0, 1'b0, '0, '0},
        '{ROW_RECORD,  tsfilt_pkg::REG_NAME, 64'h7962_6178, '0, '0,
          1'b0, 1'b0, 1'b0, '0, '0},
        '{ROW_RECORD,  tsfilt_pkg::REG_NAME, 64'h6162, '0, '0,
          1'b0, 1'b0, 1'b0, '0, '0},
        // text cut at the first zero byte, junk beyond it
        '{ROW_RECORD,  tsfilt_pkg::REG_NAME, 64'h62_0061, '0, '0,
          1'b0, 1'b0, 1'b0, '0, '0},
        '{ROW_RECORD,  tsfilt_pkg::REG_NAME, 64'h6261_00, '0, '0,
          1'b0, 1'b0, 1'b0, '0, '0},
        // occurrence in the top two bytes of a full-length field
        '{ROW_RECORD,  tsfilt_pkg::REG_NAME, 64'h6261_7a7a_7a7a_7a7a, '0, '0,
          1'b1, 1'b0, 1'b0, '0, '0},
        // full-length pattern needs an identical field
        '{ROW_PATTERN, tsfilt_pkg::REG_NAME, 64'h6867_6665_6463_6261, '0, '0,
          1'b0, 1'b0, 1'b0, '0, '0},
        '{ROW_RECORD,  tsfilt_pkg::REG_NAME, 64'h6867_6665_6463_6261, '0, '0,
          1'b0, 1'b1, 1'b1, 10'd0, 11'd1},
        '{ROW_RECORD,  tsfilt_pkg::REG_NAME, 64'h0067_6665_6463_6261, '0, '0,
          1'b0, 1'b1, 1'b0, 10'd1, 11'd1},
        // name unused (zero byte 0, junk above), high-bit surname bytes, phone "5"
        '{ROW_PATTERN, tsfilt_pkg::REG_NAME, 64'h0062_6100, '0, '0,
          1'b0, 1'b0, 1'b0, '0, '0},
        '{ROW_PATTERN, tsfilt_pkg::REG_SURNAME, 64'hff80, '0, '0,
          1'b0, 1'b0, 1'b0, '0, '0},
        '{ROW_PATTERN, tsfilt_pkg::REG_PHONE, 64'h35, '0, '0,
          1'b0, 1'b0, 1'b0, '0, '0},
        '{ROW_RECORD,  tsfilt_pkg::REG_NAME, '0, 64'hff80, 64'h35_3535,
          1'b0, 1'b0, 1'b0, '0, '0},
        '{ROW_RECORD,  tsfilt_pkg::REG_NAME, '0, 64'h80ff, 64'h35,
          1'b0, 1'b0, 1'b0, '0, '0},
        // empty phone field never matches a used pattern
        '{ROW_RECORD,  tsfilt_pkg::REG_NAME, '0, 64'hff80, '0,
          1'b0, 1'b0, 1'b0, '0, '0},
        '{ROW_RECORD,  tsfilt_pkg::REG_NAME, '0, 64'hffff_ff80, 64'h3531,
          1'b1, 1'b0, 1'b0, '0, '0},
        // all-ones phone pattern
        '{ROW_PATTERN, tsfilt_pkg::REG_NAME, '0, '0, '0,
          1'b0, 1'b0, 1'b0, '0, '0},
        '{ROW_PATTERN, tsfilt_pkg::REG_SURNAME, '0, '0, '0,
          1'b0, 1'b0, 1'b0, '0, '0},
        '{ROW_PATTERN, tsfilt_pkg::REG_PHONE, ONES, '0, '0,
          1'b0, 1'b0, 1'b0, '0, '0},
        '{ROW_RECORD,  tsfilt_pkg::REG_NAME, ONES, ONES, ONES,
          1'b0, 1'b1, 1'b1, 10'd0, 11'd1},
        '{ROW_RECORD,  tsfilt_pkg::REG_NAME, '0, '0, 64'hffff_ffff_ffff_fffe,
          1'b1, 1'b1, 1'b0, 10'd1, 11'd1}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    tsfilt_rec_if rec_ch ();
    tsfilt_res_if res_ch ();

    three_field_substring_filter_core u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .rec     (rec_ch),
        .res     (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Filter state mirrored by the testbench
    logic [TEXT_W-1:0]  pattern_regs [3] = '{'0, '0, '0};
    logic [INDEX_W-1:0] next_index  = '0;
    logic [COUNT_W-1:0] match_tally = '0;
    string              reg_label [3] = '{"name_pattern", "surname_pattern", "phone_pattern"};

    verdict_t    verdict_q [$];
    int          error_count    = 0;
    int          cycle_count    = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    logic        res_hold       = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Text length: bytes before the first zero, at most STRING_CHARS
    function automatic int unsigned text_length(input logic [TEXT_W-1:0] text);
        int unsigned n;
        n = 0;
        while (n < STRING_CHARS && text[n*8 +: 8] != 8'd0)
            n++;
        return n;
    endfunction

    function automatic logic substring_hit(input logic [TEXT_W-1:0] field,
                                           input logic [TEXT_W-1:0] pattern);
        int unsigned flen;
        int unsigned plen;
        logic        same;
        flen = text_length(field);
        plen = text_length(pattern);
        if (plen == 0 || plen > flen)
            return 1'b0;
        for (int i = 0; i + plen <= flen; i++)
        begin
            same = 1'b1;
            for (int j = 0; j < plen; j++)
                if (field[(i+j)*8 +: 8] != pattern[j*8 +: 8])
                    same = 1'b0;
            if (same)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // A pattern with zero byte 0 is not in use and always passes
    function automatic logic field_passes(input logic [TEXT_W-1:0] field,
                                          input logic [TEXT_W-1:0] pattern);
        if (pattern[7:0] == 8'd0)
            return 1'b1;
        return substring_hit(field, pattern);
    endfunction

    // Verdict for one record; advances the index and match counters
    function automatic verdict_t judge_record(input record_t r);
        verdict_t v;
        v.record_match =
            field_passes(r.name_text, pattern_regs[tsfilt_pkg::REG_NAME]) &&
            field_passes(r.surname_text, pattern_regs[tsfilt_pkg::REG_SURNAME]) &&
            field_passes(r.phone_text, pattern_regs[tsfilt_pkg::REG_PHONE]);
        if (v.record_match && match_tally < COUNT_CAP)
            match_tally++;
        v.record_index = next_index;
        v.match_count  = match_tally;
        v.list_end     = r.last_record;
        if (r.last_record)
        begin
            next_index  = '0;
            match_tally = '0;
        end
        else if (next_index < INDEX_CAP)
            next_index++;
        return v;
    endfunction

    // Field text; usually small alphabet so partial matches are common
    function automatic logic [TEXT_W-1:0] random_text(input logic [TEXT_W-1:0] pattern);
        logic [TEXT_W-1:0] text;
        int unsigned       len;
        int unsigned       plen;
        int unsigned       off;
        int unsigned       mode;
        text = '0;
        mode = $urandom_range(9);
        len  = $urandom_range(STRING_CHARS);
        for (int k = 0; k < STRING_CHARS; k++)
        begin
            if (k < len)
                text[k*8 +: 8] = (mode == 7) ? 8'($urandom_range(255, 1))
                                             : 8'($urandom_range(100, 97));
            else if (k > len && mode == 9)
                text[k*8 +: 8] = 8'($urandom);   // junk past the terminator
        end
        if (mode == 8)
        begin
            text = {$urandom, $urandom};
            len  = text_length(text);
        end
        plen = text_length(pattern);
        if (pattern[7:0] != 8'd0 && plen <= len && $urandom_range(99) < 80)
        begin
            off = $urandom_range(len - plen);
            for (int k = 0; k < plen; k++)
                text[(off+k)*8 +: 8] = pattern[k*8 +: 8];
        end
        return text;
    endfunction

    function automatic logic [TEXT_W-1:0] random_pattern();
        logic [TEXT_W-1:0] pat;
        int unsigned       len;
        int unsigned       pick;
        pat  = '0;
        pick = $urandom_range(9);
        len  = (pick < 7) ? $urandom_range(3, 1) : $urandom_range(STRING_CHARS);
        for (int k = 0; k < len; k++)
            pat[k*8 +: 8] = 8'($urandom_range(100, 97));
        if (pick == 8)
            pat = '0;
        else if (pick == 9)
            pat = {$urandom, $urandom} & ~64'hff;   // unused, junk in upper bytes
        return pat;
    endfunction

    // One APB transfer; entered and left just after a rising edge
    task automatic apb_cycle(input logic write, input logic [1:0] idx,
                             input logic [CFG_DATA_W-1:0] wdata,
                             output logic [CFG_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {idx, 3'b000};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Stop offering records and wait for every pending result
    task automatic drain();
        rec_ch.valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic program_pattern(input logic [1:0] idx, input logic [TEXT_W-1:0] value);
        logic [CFG_DATA_W-1:0] readback;
        drain();
        apb_cycle(1'b1, idx, value, readback);
        if (idx != REG_SPARE)
        begin
            pattern_regs[idx] = value;
            apb_cycle(1'b0, idx, '0, readback);
            if (readback !== value)
            begin
                $error("%s readback mismatch: expected %h, actual %h",
                       reg_label[idx], value, readback);
                error_count++;
            end
        end
    endtask

    task automatic program_random_patterns();
        program_pattern(tsfilt_pkg::REG_NAME, random_pattern());
        program_pattern(tsfilt_pkg::REG_SURNAME, random_pattern());
        program_pattern(tsfilt_pkg::REG_PHONE, random_pattern());
    endtask

    // Offer one record after a random gap; predict at the transfer edge
    task automatic send_record(input record_t r, input logic typed = 1'b0,
                               input verdict_t typed_verdict = '0);
        int unsigned gap;
        verdict_t    v;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            rec_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rec_ch.valid        <= 1'b1;
        rec_ch.name_text    <= r.name_text;
        rec_ch.surname_text <= r.surname_text;
        rec_ch.phone_text   <= r.phone_text;
        rec_ch.last_record  <= r.last_record;
        @(posedge clk);
        while (!rec_ch.ready)
            @(posedge clk);
        v = judge_record(r);
        verdict_q.push_back(typed ? typed_verdict : v);
    endtask

    // Random records; one_list keeps them in a single list closed by the last
    task automatic run_batch(input int count, input logic one_list);
        record_t r;
        for (int n = 0; n < count; n++)
        begin
            r.name_text    = random_text(pattern_regs[tsfilt_pkg::REG_NAME]);
            r.surname_text = random_text(pattern_regs[tsfilt_pkg::REG_SURNAME]);
            r.phone_text   = random_text(pattern_regs[tsfilt_pkg::REG_PHONE]);
            r.last_record  = one_list ? (n == count - 1) : ($urandom_range(99) < 5);
            send_record(r);
        end
        rec_ch.valid <= 1'b0;
    endtask

    task automatic set_idling(input int unsigned send_pct, input int unsigned stall_pct);
        send_idle_pct = send_pct;
        recv_stall_pct <= stall_pct;
    endtask

    task automatic hold_results(input int cycles);
        res_hold <= 1'b1;
        repeat (cycles) @(posedge clk);
        res_hold <= 1'b0;
    endtask

    task automatic check_verdict();
        verdict_t want;
        if (verdict_q.size() == 0)
        begin
            $error("result with no record pending: record_index %0d", res_ch.record_index);
            error_count++;
            return;
        end
        want = verdict_q.pop_front();
        if (res_ch.record_match !== want.record_match)
        begin
            $error("record_match mismatch: expected %0d, actual %0d",
                   want.record_match, res_ch.record_match);
            error_count++;
        end
        if (res_ch.record_index !== want.record_index)
        begin
            $error("record_index mismatch: expected %0d, actual %0d",
                   want.record_index, res_ch.record_index);
            error_count++;
        end
        if (res_ch.match_count !== want.match_count)
        begin
            $error("match_count mismatch: expected %0d, actual %0d",
                   want.match_count, res_ch.match_count);
            error_count++;
        end
        if (res_ch.list_end !== want.list_end)
        begin
            $error("list_end mismatch: expected %0d, actual %0d",
                   want.list_end, res_ch.list_end);
            error_count++;
        end
    endtask

    // Result side: check each transfer, then pick ready for the next cycle
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
            check_verdict();
        res_ch.ready <= !res_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        record_t  r;
        verdict_t v;

        rst_n               <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        rec_ch.valid        <= 1'b0;
        rec_ch.name_text    <= '0;
        rec_ch.surname_text <= '0;
        rec_ch.phone_text   <= '0;
        rec_ch.last_record  <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed plan
        for (int i = 0; i < PLAN_ROWS; i++)
        begin
            if (plan[i].kind == ROW_PATTERN)
                program_pattern(plan[i].reg_idx, plan[i].name_text);
            else
            begin
                r = '{plan[i].name_text, plan[i].surname_text, plan[i].phone_text,
                      plan[i].last_record};
                v = '{plan[i].hit, plan[i].index, plan[i].tally, plan[i].last_record};
                send_record(r, plan[i].typed, v);
            end
        end

        // One long list with no patterns: both counters reach saturation
        program_pattern(tsfilt_pkg::REG_NAME, '0);
        program_pattern(tsfilt_pkg::REG_SURNAME, '0);
        program_pattern(tsfilt_pkg::REG_PHONE, '0);
        run_batch(1100, 1'b1);

        // Random patterns under each idling mix
        for (int ph = 0; ph < 4; ph++)
        begin
            program_random_patterns();
            case (ph)
                0: set_idling(0, 0);
                1: set_idling(70, 0);
                2: set_idling(0, 70);
                default: set_idling(10, 10);
            endcase
            run_batch(150, 1'b0);
        end

        // Back-pressure: results held off while records keep coming
        program_random_patterns();
        set_idling(0, 0);
        fork
            hold_results(HOLD_CYCLES);
            run_batch(80, 1'b0);
        join
        drain();
        set_idling(30, 30);
        run_batch(40, 1'b0);

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && verdict_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> filelist.f
rtl/tsfilt_pkg.sv
rtl/tsfilt_rec_if.sv
rtl/tsfilt_res_if.sv
rtl/tsfilt_lane.sv
rtl/tsfilt_merge.sv
rtl/three_field_substring_filter_core.sv
tb/three_field_substring_filter_core_test.sv
